### rtl/core/xxh_pkg.sv
// xxh_pkg: constants and helper functions of the streaming XXH64 hash block.
// Holds the five XXH64 primes, a fixed-amount left rotate and the lane start values.
// No dependencies.
`timescale 1ns / 1ps

package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	// rotate left; n is always a constant between 1 and 63 at the call site
	function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	// start value of one lane accumulator for a given seed
	function automatic logic [63:0] init_lane(input logic [63:0] s, input logic [1:0] idx);
		logic [63:0] r;
		case (idx)
			2'd0: r = s + P1 + P2;
			2'd1: r = s + P2;
			2'd2: r = s;
			default: r = s - P1;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/xxh64_stream_hash_top.sv
// xxh64_stream_hash_top: streaming XXH64 hash engine, one byte per input request.
// Depends on xxh_pkg (primes, rotate, lane start values).
`timescale 1ns / 1ps

// Streaming XXH64 of a byte message under a 64-bit seed. Each input request carries
// at most one byte (byte_valid) and may close the message (end_of_message); one
// digest request follows each closing request. Writing the seed restarts the current
// message. All multiplies share one 32x32 multiplier: a 64-bit product modulo 2^64
// is built from low-by-low, two cross terms and a final add. A byte that neither
// closes a 32-byte stripe nor ends the message leaves the engine idle, so in_ready
// stays high. A stripe-closing byte holds the input while each lane takes one
// word-store read and two multiplies. At end of message the input waits through the
// lane merge and fold if 32 or more bytes were seen, the length fold, a read and
// three multiplies per full tail word, a four-byte step if four or more odd bytes
// remain, one step per remaining single byte and the avalanche, after the stripe
// update if the closing request completes a stripe, and longer while the previous
// digest is untaken. The digest sits in an output register, so the next message may
// stream in while it waits. A pending seed write takes priority over input requests.
module xxh64_stream_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	// seed write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed,
	// byte input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	// digest output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_ARD,  // read stripe word k for the lane update
		S_AM1,  // word * P2
		S_AM2,  // rot(acc + t, 31) * P1
		S_FIN,  // choose long or short start
		S_MRG,  // sum of rotated lanes, one lane a cycle
		S_FM1,  // lane * P2
		S_FM2,  // rot(., 31) * P1
		S_FM3,  // (h ^ m) * P1 + P4
		S_LEN,  // fold in message length
		S_TAIL, // dispatch the next tail step
		S_TRD,  // read tail word k
		S_TM1,  // word * P2
		S_TM2,  // rot(., 31) * P1
		S_TM3,  // rot(h ^ m, 27) * P1 + P4
		S_Q1,   // four-byte step: w * P1
		S_Q2,   // rot(h ^ ., 23) * P2 + P3
		S_B1,   // single byte: b * P5
		S_B2,   // rot(h ^ ., 11) * P1
		S_AV0,  // avalanche: h ^ h >> 33
		S_V1,   // * P2, then ^ >> 29
		S_V2    // * P3, then ^ >> 32, emit
	} state_t;

	state_t      state_q;
	logic [1:0]  ph_q;        // multiply phase
	logic [1:0]  k_q;         // lane / tail word index
	logic [4:0]  fill_q;      // bytes held in the current stripe
	logic [63:0] len_q;       // total message length
	logic        fin_pend_q;  // end of message seen with the stripe-closing byte
	logic [63:0] seed_q;
	logic [63:0] acc_q [4];
	logic [63:0] wbuf_q;      // word being assembled
	logic [63:0] tb_q;        // partial tail word, shifted down as consumed
	logic [2:0]  rem_q;       // odd tail bytes left
	logic [63:0] h_q;
	logic [63:0] opa_q;
	logic        out_valid_q;
	logic [63:0] digest_q;

	// word store: four 64-bit stripe words
	logic [63:0] word_mem [4];
	logic [63:0] rd_q;
	logic        rd_en;
	logic        wr_en;

	// shared multiplier
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] prod_q;
	logic [63:0] res_q;
	logic [63:0] mres;
	logic        mul_done;
	logic [63:0] mrg_term;

	logic in_acc;
	logic cfg_acc;
	logic long_msg;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_valid = out_valid_q;
	assign digest    = digest_q;
	assign long_msg  = |len_q[63:5];

	assign rd_en = (state_q == S_ARD) || (state_q == S_TRD);
	assign wr_en = in_acc && byte_valid && (fill_q[2:0] == 3'd7);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_mem[fill_q[4:3]] <= {data_byte, wbuf_q[55:0]};
		end
		if (rd_en) begin
			rd_q <= word_mem[k_q];
		end
	end

	// operand A: taken straight from its source where it is stable for the multiply
	always_comb begin
		case (state_q)
			S_AM1, S_TM1: mul_a = rd_q;
			S_FM1:        mul_a = acc_q[k_q];
			S_Q1:         mul_a = {32'd0, tb_q[31:0]};
			S_B1:         mul_a = {56'd0, tb_q[7:0]};
			default:      mul_a = opa_q;
		endcase
	end

	always_comb begin
		case (state_q)
			S_AM1, S_FM1, S_TM1, S_Q2, S_V1: mul_b = xxh_pkg::P2;
			S_B1:                            mul_b = xxh_pkg::P5;
			S_V2:                            mul_b = xxh_pkg::P3;
			default:                         mul_b = xxh_pkg::P1;
		endcase
	end

	// low 64 bits of a 64x64 product: alo*blo, then the two cross terms into the top half
	assign mx = (ph_q == 2'd2) ? mul_a[63:32] : mul_a[31:0];
	assign my = (ph_q == 2'd1) ? mul_b[63:32] : mul_b[31:0];

	always_ff @(posedge clk) begin
		if (ph_q != 2'd3) begin
			prod_q <= 64'(mx) * 64'(my);
		end
		if (ph_q == 2'd1) begin
			res_q <= prod_q;
		end else if (ph_q == 2'd2) begin
			res_q[63:32] <= res_q[63:32] + prod_q[31:0];
		end
	end

	assign mres = {res_q[63:32] + prod_q[31:0], res_q[31:0]};

	always_comb begin
		mul_done = 1'b0;
		if (state_q inside {S_AM1, S_AM2, S_FM1, S_FM2, S_FM3, S_TM1, S_TM2, S_TM3,
				S_Q1, S_Q2, S_B1, S_B2, S_V1, S_V2}) begin
			mul_done = (ph_q == 2'd3);
		end
	end

	// merge term for the long-message start
	always_comb begin
		case (k_q)
			2'd0:    mrg_term = xxh_pkg::rotl(acc_q[0], 1);
			2'd1:    mrg_term = xxh_pkg::rotl(acc_q[1], 7);
			2'd2:    mrg_term = xxh_pkg::rotl(acc_q[2], 12);
			default: mrg_term = xxh_pkg::rotl(acc_q[3], 18);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 2'd0;
			k_q         <= 2'd0;
			fill_q      <= 5'd0;
			len_q       <= 64'd0;
			fin_pend_q  <= 1'b0;
			seed_q      <= 64'd0;
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= xxh_pkg::init_lane(64'd0, 2'(i));
			end
			wbuf_q      <= 64'd0;
			tb_q        <= 64'd0;
			rem_q       <= 3'd0;
			h_q         <= 64'd0;
			opa_q       <= 64'd0;
			out_valid_q <= 1'b0;
			digest_q    <= 64'd0;
		end else begin
			// drop the digest once taken, unless a new one replaces it
			if (out_valid_q && out_ready && !(state_q == S_V2 && mul_done)) begin
				out_valid_q <= 1'b0;
			end

			// advance the multiply phase; the owning state consumes the result
			if (mul_done) begin
				// a stalled final multiply keeps its phase so the product stays in place
				if (!(state_q == S_V2 && out_valid_q && !out_ready)) begin
					ph_q <= 2'd0;
				end
			end else if (ph_q != 2'd3 && state_q inside {S_AM1, S_AM2, S_FM1, S_FM2, S_FM3,
					S_TM1, S_TM2, S_TM3, S_Q1, S_Q2, S_B1, S_B2, S_V1, S_V2}) begin
				ph_q <= ph_q + 2'd1;
			end

			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						seed_q <= seed;
						for (int i = 0; i < 4; i++) begin
							acc_q[i] <= xxh_pkg::init_lane(seed, 2'(i));
						end
						fill_q <= 5'd0;
						len_q  <= 64'd0;
					end else if (in_acc) begin
						if (byte_valid) begin
							wbuf_q[{fill_q[2:0], 3'b000} +: 8] <= data_byte;
							fill_q <= fill_q + 5'd1;
							len_q  <= len_q + 64'd1;
						end
						if (byte_valid && fill_q == 5'd31) begin
							k_q        <= 2'd0;
							fin_pend_q <= end_of_message;
							state_q    <= S_ARD;
						end else if (end_of_message) begin
							state_q <= S_FIN;
						end
					end
				end

				S_ARD: state_q <= S_AM1;

				S_AM1: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(acc_q[k_q] + mres, 31);
						state_q <= S_AM2;
					end
				end

				S_AM2: begin
					if (mul_done) begin
						acc_q[k_q] <= mres;
						k_q        <= k_q + 2'd1;
						if (k_q == 2'd3) begin
							fin_pend_q <= 1'b0;
							state_q    <= fin_pend_q ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_ARD;
						end
					end
				end

				S_FIN: begin
					tb_q  <= wbuf_q;
					rem_q <= fill_q[2:0];
					k_q   <= 2'd0;
					if (long_msg) begin
						h_q     <= 64'd0;
						state_q <= S_MRG;
					end else begin
						h_q     <= seed_q + xxh_pkg::P5;
						state_q <= S_LEN;
					end
				end

				S_MRG: begin
					h_q <= h_q + mrg_term;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= S_FM1;
					end
				end

				S_FM1: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(mres, 31);
						state_q <= S_FM2;
					end
				end

				S_FM2: begin
					if (mul_done) begin
						opa_q   <= h_q ^ mres;
						state_q <= S_FM3;
					end
				end

				S_FM3: begin
					if (mul_done) begin
						h_q     <= mres + xxh_pkg::P4;
						k_q     <= k_q + 2'd1;
						state_q <= (k_q == 2'd3) ? S_LEN : S_FM1;
					end
				end

				S_LEN: begin
					h_q     <= h_q + len_q;
					k_q     <= 2'd0;
					state_q <= S_TAIL;
				end

				S_TAIL: begin
					if (k_q != fill_q[4:3]) begin
						state_q <= S_TRD;
					end else if (rem_q[2]) begin
						state_q <= S_Q1;
					end else if (rem_q != 3'd0) begin
						state_q <= S_B1;
					end else begin
						state_q <= S_AV0;
					end
				end

				S_TRD: state_q <= S_TM1;

				S_TM1: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(mres, 31);
						state_q <= S_TM2;
					end
				end

				S_TM2: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(h_q ^ mres, 27);
						state_q <= S_TM3;
					end
				end

				S_TM3: begin
					if (mul_done) begin
						h_q     <= mres + xxh_pkg::P4;
						k_q     <= k_q + 2'd1;
						state_q <= S_TAIL;
					end
				end

				S_Q1: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(h_q ^ mres, 23);
						state_q <= S_Q2;
					end
				end

				S_Q2: begin
					if (mul_done) begin
						h_q     <= mres + xxh_pkg::P3;
						tb_q    <= {32'd0, tb_q[63:32]};
						rem_q   <= rem_q - 3'd4;
						state_q <= S_TAIL;
					end
				end

				S_B1: begin
					if (mul_done) begin
						opa_q   <= xxh_pkg::rotl(h_q ^ mres, 11);
						state_q <= S_B2;
					end
				end

				S_B2: begin
					if (mul_done) begin
						h_q     <= mres;
						tb_q    <= {8'd0, tb_q[63:8]};
						rem_q   <= rem_q - 3'd1;
						state_q <= S_TAIL;
					end
				end

				S_AV0: begin
					opa_q   <= h_q ^ (h_q >> 33);
					state_q <= S_V1;
				end

				S_V1: begin
					if (mul_done) begin
						opa_q   <= mres ^ (mres >> 29);
						state_q <= S_V2;
					end
				end

				S_V2: begin
					// hold the finished product while the previous digest still waits
					if (mul_done && (!out_valid_q || out_ready)) begin
						digest_q    <= mres ^ (mres >> 32);
						out_valid_q <= 1'b1;
						for (int i = 0; i < 4; i++) begin
							acc_q[i] <= xxh_pkg::init_lane(seed_q, 2'(i));
						end
						fill_q  <= 5'd0;
						len_q   <= 64'd0;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/xxh_checker.sv
// xxh_checker: port-level assertions for xxh64_stream_hash_top, and the bind that
// attaches them. Depends on the top level's port list only.
`timescale 1ns / 1ps

module xxh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        byte_valid,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] digest
);

	// a waiting digest holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest))
		else $error("digest changed or dropped while stalled");

	// closing request always starts the finish sequence
	a_eom_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_message |=> !in_ready)
		else $error("input taken right after end of message");

	// a digest only appears after the engine was busy
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("digest raised without a finish sequence");

	// a seed write keeps the byte channel off
	a_cfg_prio: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> !in_ready)
		else $error("input ready during a seed write");

	// an empty request leaves the input ready unless a seed write is pending
	a_empty_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !byte_valid && !end_of_message |=> in_ready || cfg_valid)
		else $error("empty request stalled the input");

endmodule

bind xxh64_stream_hash_top xxh_checker u_xxh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_valid      (cfg_valid),
	.cfg_ready      (cfg_ready),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.byte_valid     (byte_valid),
	.end_of_message (end_of_message),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.digest         (digest)
);
